### rtl/alias_table_sampler_assert.svh
// ----------------------------------------------------------------------------
// Alias table sampler assertion macros
// Concurrent check wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ALIAS_TABLE_SAMPLER_ASSERT_SVH
`define ALIAS_TABLE_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define ATS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ATS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ATS_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define ATS_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

### rtl/ats_pkg.sv
// ----------------------------------------------------------------------------
// Alias table sampler package
// Sizes, item and result types, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int MAX_ENTRIES   = 256;
  localparam int IDX_W         = 8;
  localparam int CNT_W         = 9;
  localparam int WEIGHT_BITS   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int UNIFORM_BITS  = 16;
  localparam int SUM_W         = 24;
  localparam int PROB_W        = FRACTION_BITS + 1;
  localparam int SCALED_W      = UNIFORM_BITS + IDX_W;
  localparam int PROD_W        = UNIFORM_BITS + SUM_W;
  localparam int REM_W         = SUM_W + 1;
  localparam int DIV_STEPS     = FRACTION_BITS + 1;
  localparam int DIV_CNT_W     = 5;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   last;
    logic [UNIFORM_BITS-1:0] uniform;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [PROB_W-1:0] probability;
    logic              empty_table;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] threshold;
    logic             full;
    logic [IDX_W-1:0] alias_idx;
  } link_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_MUL,
    ST_INIT_DIV,
    ST_PAIR_POP,
    ST_PAIR_SMALL,
    ST_PAIR_LARGE,
    ST_PAIR_UPD,
    ST_SAMP_MUL,
    ST_SAMP_RD,
    ST_SAMP_PICK,
    ST_SAMP_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic sample;
    logic init_wr;
    logic div_step;
    logic pop;
    logic grab_small;
    logic grab_large;
    logic pair_wr;
    logic samp_mul;
    logic samp_rd;
    logic samp_pick;
  } cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic div_last;
    logic entry_last;
    logic pairs_left;
    logic empty;
  } status_t;

endpackage

### rtl/ats_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ats_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ats_datapath.sv
// ----------------------------------------------------------------------------
// Alias table sampler datapath
// Table memories, stacks, counters, the probability divider and sample math.
// ----------------------------------------------------------------------------
module ats_datapath import ats_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output status_t status,
  output result_t result
);

  logic [CNT_W-1:0]     entry_count;
  logic [SUM_W-1:0]     weight_sum;
  logic                 table_ready;
  logic [CNT_W-1:0]     small_count;
  logic [CNT_W-1:0]     large_count;
  logic [CNT_W-1:0]     entry_ptr;
  logic [UNIFORM_BITS-1:0] uniform_reg;
  logic [SCALED_W-1:0]  scaled;
  logic [PROD_W-1:0]    product;
  logic [IDX_W-1:0]     pick;
  logic                 empty_flag;
  logic [IDX_W-1:0]     small_sel;
  logic [IDX_W-1:0]     large_sel;
  logic [SUM_W-1:0]     mass_small;
  logic [REM_W-1:0]     rem;
  logic [PROB_W-1:0]    quot;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [CNT_W-1:0]     base_count;
  logic [SUM_W-1:0]     base_sum;
  logic                 room;

  logic [WEIGHT_BITS-1:0] weight_rdata;
  logic [SUM_W-1:0]       mass_rdata;
  logic [IDX_W-1:0]       small_rdata;
  logic [IDX_W-1:0]       large_rdata;
  link_t                  link_rdata;
  link_t                  link_wdata;
  logic [PROB_W-1:0]      prob_rdata;

  logic [WEIGHT_BITS+CNT_W-1:0] mass_full;
  logic [SUM_W-1:0]       mass_calc;
  logic [SUM_W-1:0]       deficit;
  logic [SUM_W-1:0]       mass_new;
  logic [SUM_W-1:0]       push_mass;
  logic [IDX_W-1:0]       push_id;
  logic                   push_small;
  logic                   push_large;
  logic [CNT_W-1:0]       small_top;
  logic [CNT_W-1:0]       large_top;
  logic                   table_wr;

  logic [REM_W-1:0]       trial;
  logic                   qbit;
  logic [REM_W-1:0]       rem_next;
  logic [PROB_W-1:0]      quot_next;

  logic [UNIFORM_BITS+CNT_W-1:0] scaled_full;
  logic [IDX_W-1:0]       draw_idx;
  logic                   take_direct;
  logic [IDX_W-1:0]       pick_calc;

  assign base_count = table_ready ? '0 : entry_count;
  assign base_sum   = table_ready ? '0 : weight_sum;
  assign room       = base_count < CNT_W'(MAX_ENTRIES);

  // Build arithmetic.
  assign mass_full = weight_rdata * entry_count;
  assign mass_calc = mass_full[SUM_W-1:0];
  assign deficit   = weight_sum - mass_small;
  assign mass_new  = (mass_rdata > deficit) ? mass_rdata - deficit : '0;
  assign push_mass = cmd.init_wr ? mass_calc : mass_new;
  assign push_id   = cmd.init_wr ? entry_ptr[IDX_W-1:0] : large_sel;
  assign table_wr  = cmd.init_wr || cmd.pair_wr;
  assign push_small = table_wr && (push_mass < weight_sum);
  assign push_large = table_wr && (push_mass > weight_sum);
  assign small_top = small_count - 1'b1;
  assign large_top = large_count - 1'b1;

  assign link_wdata = cmd.init_wr ?
      link_t'{threshold: weight_sum, full: 1'b1, alias_idx: entry_ptr[IDX_W-1:0]} :
      link_t'{threshold: mass_small, full: 1'b0, alias_idx: large_sel};

  // Restoring divider for weight * 2^FRACTION_BITS / sum. The first step
  // takes the weight unshifted, which yields the integer bit.
  assign trial     = (div_cnt == '0) ? rem : {rem[REM_W-2:0], 1'b0};
  assign qbit      = trial >= {1'b0, weight_sum};
  assign rem_next  = qbit ? trial - {1'b0, weight_sum} : trial;
  assign quot_next = {quot[PROB_W-2:0], qbit};

  // Sample arithmetic.
  assign scaled_full = uniform_reg * entry_count;
  assign draw_idx    = scaled[UNIFORM_BITS +: IDX_W];
  assign take_direct = link_rdata.full ||
                       (product < {link_rdata.threshold, UNIFORM_BITS'(0)});
  always_comb begin
    pick_calc = take_direct ? draw_idx : link_rdata.alias_idx;
    if ({1'b0, pick_calc} >= entry_count) begin
      pick_calc = draw_idx;
    end
  end

  ats_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_weight_ram (
    .clk   (clk),
    .we    (cmd.load && room),
    .waddr (base_count[IDX_W-1:0]),
    .wdata (item.weight),
    .raddr (entry_ptr[IDX_W-1:0]),
    .rdata (weight_rdata)
  );

  ats_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ENTRIES)) u_mass_ram (
    .clk   (clk),
    .we    (table_wr),
    .waddr (cmd.init_wr ? entry_ptr[IDX_W-1:0] : large_sel),
    .wdata (push_mass),
    .raddr (cmd.grab_small ? small_rdata : large_sel),
    .rdata (mass_rdata)
  );

  ats_ram #(.WIDTH($bits(link_t)), .DEPTH(MAX_ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (table_wr),
    .waddr (cmd.init_wr ? entry_ptr[IDX_W-1:0] : small_sel),
    .wdata (link_wdata),
    .raddr (draw_idx),
    .rdata (link_rdata)
  );

  ats_ram #(.WIDTH(PROB_W), .DEPTH(MAX_ENTRIES)) u_prob_ram (
    .clk   (clk),
    .we    (cmd.div_step && status.div_last),
    .waddr (entry_ptr[IDX_W-1:0]),
    .wdata (quot_next),
    .raddr (pick_calc),
    .rdata (prob_rdata)
  );

  ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_small_stack (
    .clk   (clk),
    .we    (push_small),
    .waddr (small_count[IDX_W-1:0]),
    .wdata (push_id),
    .raddr (small_top[IDX_W-1:0]),
    .rdata (small_rdata)
  );

  ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_large_stack (
    .clk   (clk),
    .we    (push_large),
    .waddr (large_count[IDX_W-1:0]),
    .wdata (push_id),
    .raddr (large_top[IDX_W-1:0]),
    .rdata (large_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      weight_sum  <= '0;
      table_ready <= 1'b0;
      small_count <= '0;
      large_count <= '0;
      entry_ptr   <= '0;
    end else begin
      if (cmd.load) begin
        // A load after a finished build starts a fresh table.
        table_ready <= item.last;
        entry_count <= room ? base_count + 1'b1 : base_count;
        weight_sum  <= room ? base_sum + SUM_W'(item.weight) : base_sum;
        small_count <= '0;
        large_count <= '0;
        entry_ptr   <= '0;
      end
      if (cmd.pop) begin
        small_count <= small_top;
        large_count <= large_top;
      end
      if (push_small) begin
        small_count <= small_count + 1'b1;
      end
      if (push_large) begin
        large_count <= large_count + 1'b1;
      end
      if (cmd.div_step && status.div_last) begin
        entry_ptr <= entry_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      uniform_reg <= item.uniform;
      empty_flag  <= status.empty;
    end
    if (cmd.samp_mul) begin
      scaled <= scaled_full[SCALED_W-1:0];
    end
    if (cmd.samp_rd) begin
      product <= scaled[UNIFORM_BITS-1:0] * weight_sum;
    end
    if (cmd.samp_pick) begin
      pick <= pick_calc;
    end
    if (cmd.init_wr) begin
      rem     <= REM_W'(weight_rdata);
      quot    <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= rem_next;
      quot    <= quot_next;
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.grab_small) begin
      small_sel <= small_rdata;
      large_sel <= large_rdata;
    end
    if (cmd.grab_large) begin
      mass_small <= mass_rdata;
    end
  end

  assign status.sum_zero   = weight_sum == '0;
  assign status.div_last   = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
  assign status.entry_last = (entry_ptr + 1'b1) == entry_count;
  assign status.pairs_left = (small_count != '0) && (large_count != '0);
  assign status.empty      = !table_ready || (weight_sum == '0) || (entry_count == '0);

  assign result = empty_flag ?
      result_t'{index: '0, probability: '0, empty_table: 1'b1} :
      result_t'{index: pick, probability: prob_rdata, empty_table: 1'b0};

endmodule

### rtl/ats_controller.sv
// ----------------------------------------------------------------------------
// Alias table sampler controller
// Sequences loads, the table build and the sample draw.
// ----------------------------------------------------------------------------
`include "alias_table_sampler_assert.svh"

module ats_controller import ats_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    item_kind,
  input  logic    item_last,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (item_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
            if (item_last) begin
              state_next = ST_INIT_RD;
            end
          end else begin
            cmd.sample = 1'b1;
            state_next = status.empty ? ST_SAMP_OUT : ST_SAMP_MUL;
          end
        end
      end
      ST_INIT_RD: begin
        // A zero sum leaves the table empty.
        state_next = status.sum_zero ? ST_IDLE : ST_INIT_MUL;
      end
      ST_INIT_MUL: begin
        cmd.init_wr = 1'b1;
        state_next  = ST_INIT_DIV;
      end
      ST_INIT_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = status.entry_last ? ST_PAIR_POP : ST_INIT_RD;
        end
      end
      ST_PAIR_POP: begin
        if (status.pairs_left) begin
          cmd.pop    = 1'b1;
          state_next = ST_PAIR_SMALL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAIR_SMALL: begin
        cmd.grab_small = 1'b1;
        state_next     = ST_PAIR_LARGE;
      end
      ST_PAIR_LARGE: begin
        cmd.grab_large = 1'b1;
        state_next     = ST_PAIR_UPD;
      end
      ST_PAIR_UPD: begin
        cmd.pair_wr = 1'b1;
        state_next  = ST_PAIR_POP;
      end
      ST_SAMP_MUL: begin
        cmd.samp_mul = 1'b1;
        state_next   = ST_SAMP_RD;
      end
      ST_SAMP_RD: begin
        cmd.samp_rd = 1'b1;
        state_next  = ST_SAMP_PICK;
      end
      ST_SAMP_PICK: begin
        cmd.samp_pick = 1'b1;
        state_next    = ST_SAMP_OUT;
      end
      ST_SAMP_OUT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ATS_ASSERT_NXT(a_sample_holds_busy, clk, rst, start && !busy && item_kind == KIND_SAMPLE, busy)
  `ATS_ASSERT_NXT(a_load_streams, clk, rst, start && !busy && item_kind == KIND_LOAD && !item_last, !busy)
  `ATS_ASSERT_NXT(a_done_frees, clk, rst, done, !busy)
  `ATS_ASSERT_IMP(a_done_not_idle, clk, rst, done, busy)

endmodule

### rtl/alias_table_sampler.sv
// ----------------------------------------------------------------------------
// Alias table sampler
// Weighted sampling from an exact-integer Vose alias table.
// ----------------------------------------------------------------------------
// Load items stream one per cycle while busy is low. The load marked last
// starts the build, and busy stays high until it ends. Each entry takes a
// weight read, the scaled mass, and a 17-step serial divider for its
// probability. Then each small/large pairing runs pop, small, large and update
// states, as the stack reads and the mass reads all have registered data and
// follow one another. There are at most N-1 pairings, and a final pop check
// with no pairs left ends the build. A zero weight sum ends the build at the
// weight read state. A sample transfer keeps busy high through multiply,
// table read with multiply, compare and probability read, and result. It puts
// its result on result with done high for exactly one cycle, and the receiver
// must take it then. A sample on an empty table goes straight to the result
// state. Memory contents are undefined after reset and need no clearing pass.
module alias_table_sampler import ats_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  cmd_t    cmd;
  status_t status;

  ats_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item_kind (item.kind),
    .item_last (item.last),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  ats_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule
